FILE: hdl/qdwc_pkg.sv
// Shared types and constants for the quadrature decoder with wrapping counter.
package qdwc_pkg;

	// Fixed field widths
	localparam int LOAD_W          = 16;
	localparam int POS_W           = 16;
	localparam int LIMIT_W         = 14;
	localparam int SCALE_W         = 32;
	localparam int SCALE_FRAC_BITS = 24;
	localparam int ANGLE_W         = 10 + SCALE_FRAC_BITS;
	localparam int APB_ADDR_W      = 4;
	localparam int APB_DATA_W      = 32;

	// Shared adder is as wide as the angle; that also covers a 32-bit count plus headroom
	localparam int ALU_W     = ANGLE_W;
	localparam int DIV_CNT_W = $clog2(LOAD_W);

	// Register reset values
	localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(2048);
	localparam logic [SCALE_W-1:0] DEFAULT_SCALE = SCALE_W'(25736);

	// Request opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Register indexes (word address)
	typedef enum logic [1:0] {
		REG_LIMIT  = 2'd0,
		REG_SCALE  = 2'd1,
		REG_ENABLE = 2'd2
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_CMP_HI,
		ST_CMP_LO,
		ST_WRAP_SUB,
		ST_WRAP_ADD,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_MAG,
		ST_MUL,
		ST_SAT,
		ST_ANG
	} state_t;

	// Shared adder request and response
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             neg;
		logic             zero;
	} alu_rsp_t;

endpackage

FILE: hdl/qdwc_if.sv
// Request and result channel interfaces of the quadrature decoder.
interface qdwc_in_if;
	import qdwc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic                     pin_a;
	logic                     pin_b;
	logic signed [LOAD_W-1:0] load_value;

	modport source (output valid, opcode, pin_a, pin_b, load_value, input ready);
	modport sink   (input valid, opcode, pin_a, pin_b, load_value, output ready);
endinterface

interface qdwc_out_if;
	import qdwc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [POS_W-1:0]   position_count;
	logic                      turning_clockwise;
	logic signed [ANGLE_W-1:0] angle;
	logic                      missed_edge;

	modport source (output valid, position_count, turning_clockwise, angle, missed_edge,
		input ready);
	modport sink   (input valid, position_count, turning_clockwise, angle, missed_edge,
		output ready);
endinterface

FILE: hdl/qdwc_alu.sv
// Shared add/subtract unit with sign and zero flags.
module qdwc_alu (
	input  qdwc_pkg::alu_req_t req,
	output qdwc_pkg::alu_rsp_t rsp
);
	import qdwc_pkg::*;

	logic [ALU_W-1:0] b_op;
	logic [ALU_W-1:0] sum;

	// a + b, or a - b as a + ~b + 1
	always_comb begin
		b_op     = req.sub ? ~req.b : req.b;
		sum      = req.a + b_op + ALU_W'(req.sub);
		rsp.sum  = sum;
		rsp.neg  = sum[ALU_W-1];
		rsp.zero = (sum == '0);
	end

endmodule

FILE: hdl/quadrature_decoder_wrap_counter.sv
// Quadrature decoder (x4) with wrapping position counter and angle output.
// One request is taken at a time; ready is high only while the sequencer is idle, and a
// finished result waits in the output register without holding off the next request.
// All arithmetic (count step, wrap compares, load remainder, negations) runs through
// one shared adder, one sequencer state per use. A pin sample without a counted edge
// runs magnitude, multiply, saturate and angle; a counted edge first adds step, compare
// against +limit, compare against -limit and a wrap when needed; a load first adds
// magnitude, 16 restoring-division steps for the remainder, and sign fix-up.
// The angle is |count| * angle_scale from one registered multiply, saturated to the
// signed 34-bit range. Configuration sits on an APB port at byte addresses 0, 4, 8.
module quadrature_decoder_wrap_counter #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	qdwc_in_if.sink                             item,
	qdwc_out_if.source                          res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [qdwc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [qdwc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [qdwc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import qdwc_pkg::*;

	localparam int PROD_W = COUNT_WIDTH + SCALE_W;
	localparam logic [PROD_W-1:0] POS_MAX = PROD_W'((64'd1 << (ANGLE_W - 1)) - 64'd1);
	localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(64'd1 << (ANGLE_W - 1));

	// Configuration registers
	logic [LIMIT_W-1:0] limit_q;
	logic [SCALE_W-1:0] scale_q;
	logic               enable_q;

	// Decoder state
	state_t                        state_q, state_d;
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic                          dir_q;
	logic                          prev_a_q;
	logic                          prev_b_q;
	logic                          miss_q;

	// Working registers
	logic [ALU_W-1:0]       work_q;
	logic signed [LOAD_W-1:0] load_q;
	logic [LOAD_W-1:0]      dvd_q;
	logic [LOAD_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [COUNT_WIDTH-1:0] mag_q;
	logic [PROD_W-1:0]      prod_q;
	logic [ANGLE_W-1:0]     sat_q;

	// Output register
	logic                      out_valid_q;
	logic signed [POS_W-1:0]   out_pos_q;
	logic                      out_dir_q;
	logic signed [ANGLE_W-1:0] out_angle_q;
	logic                      out_miss_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic               accept;
	logic               edge_a;
	logic               edge_b;
	logic               step_go;
	logic               step_cw;
	logic               div_last;
	logic               out_space;
	logic               out_load;
	logic               load_neg;
	logic               cnt_neg;
	logic [LIMIT_W-1:0] eff_limit;
	logic [LIMIT_W:0]   span;
	logic [LOAD_W:0]    trial;
	logic               cfg_wr;

	qdwc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Request decode
	assign accept    = item.valid & item.ready;
	assign edge_a    = item.pin_a ^ prev_a_q;
	assign edge_b    = item.pin_b ^ prev_b_q;
	assign step_go   = enable_q & (edge_a ^ edge_b);
	assign step_cw   = edge_a ? (item.pin_a == item.pin_b) : (item.pin_a != item.pin_b);
	assign div_last  = (div_cnt_q == DIV_CNT_W'(LOAD_W - 1));
	assign out_space = ~out_valid_q | res.ready;
	assign out_load  = (state_q == ST_ANG) & out_space;
	assign load_neg  = load_q[LOAD_W-1];
	assign cnt_neg   = count_q[COUNT_WIDTH-1];
	assign eff_limit = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
	assign span      = {eff_limit, 1'b0};
	assign trial     = {rem_q, dvd_q[LOAD_W-1]};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.opcode == OP_LOAD)
						state_d = ST_ABS;
					else if (step_go)
						state_d = ST_STEP;
					else
						state_d = ST_MAG;
				end
			end
			ST_STEP:     state_d = ST_CMP_HI;
			ST_CMP_HI:   state_d = alu_rsp.neg ? ST_CMP_LO : ST_WRAP_SUB;
			ST_CMP_LO:   state_d = (alu_rsp.neg | alu_rsp.zero) ? ST_WRAP_ADD : ST_MAG;
			ST_WRAP_SUB: state_d = ST_MAG;
			ST_WRAP_ADD: state_d = ST_MAG;
			ST_ABS:      state_d = ST_DIV;
			ST_DIV:      state_d = div_last ? ST_SIGN : ST_DIV;
			ST_SIGN:     state_d = ST_MAG;
			ST_MAG:      state_d = ST_MUL;
			ST_MUL:      state_d = ST_SAT;
			ST_SAT:      state_d = ST_ANG;
			ST_ANG:      state_d = out_space ? ST_IDLE : ST_ANG;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and shared adder operands
	always_comb begin
		item.ready  = (state_q == ST_IDLE);
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			ST_STEP: begin
				alu_req.a   = ALU_W'(count_q);
				alu_req.b   = ALU_W'(1);
				alu_req.sub = ~dir_q;
			end
			ST_CMP_HI: begin
				alu_req.a   = work_q;
				alu_req.b   = ALU_W'(eff_limit);
				alu_req.sub = 1'b1;
			end
			ST_CMP_LO: begin
				alu_req.a   = work_q;
				alu_req.b   = ALU_W'(eff_limit);
				alu_req.sub = 1'b0;
			end
			ST_WRAP_SUB: begin
				alu_req.a   = work_q;
				alu_req.b   = ALU_W'(span);
				alu_req.sub = 1'b1;
			end
			ST_WRAP_ADD: begin
				alu_req.a   = work_q;
				alu_req.b   = ALU_W'(span);
				alu_req.sub = 1'b0;
			end
			ST_ABS: begin
				alu_req.b   = ALU_W'(load_q);
				alu_req.sub = load_neg;
			end
			ST_DIV: begin
				alu_req.a   = ALU_W'(trial);
				alu_req.b   = ALU_W'(span);
				alu_req.sub = 1'b1;
			end
			ST_SIGN: begin
				alu_req.b   = ALU_W'(rem_q);
				alu_req.sub = load_neg;
			end
			ST_MAG: begin
				alu_req.b   = ALU_W'(count_q);
				alu_req.sub = cnt_neg;
			end
			ST_ANG: begin
				alu_req.b   = ALU_W'(sat_q);
				alu_req.sub = cnt_neg;
			end
			default: begin
				alu_req.a   = '0;
			end
		endcase
	end

	// Sequencer and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dir_q     <= 1'b1;
			prev_a_q  <= 1'b1;
			prev_b_q  <= 1'b1;
			miss_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				miss_q <= 1'b0;
				if (item.opcode == OP_SAMPLE) begin
					prev_a_q <= item.pin_a;
					prev_b_q <= item.pin_b;
					miss_q   <= enable_q & edge_a & edge_b;
					if (step_go)
						dir_q <= step_cw;
				end
			end
			// Count commits once the wrap decision is known
			unique case (state_q) inside
				ST_CMP_LO: begin
					if (!(alu_rsp.neg | alu_rsp.zero))
						count_q <= work_q[COUNT_WIDTH-1:0];
				end
				ST_WRAP_SUB, ST_WRAP_ADD, ST_SIGN: count_q <= alu_rsp.sum[COUNT_WIDTH-1:0];
				default: count_q <= count_q;
			endcase
			// Division step counter
			if (state_q == ST_DIV)
				div_cnt_q <= div_last ? '0 : div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// Datapath working registers
	always_ff @(posedge clk) begin
		if (accept)
			load_q <= item.load_value;
		if (state_q == ST_STEP)
			work_q <= alu_rsp.sum;
		// Restoring division of |load| by 2*limit, one quotient bit per cycle
		if (state_q == ST_ABS) begin
			dvd_q <= alu_rsp.sum[LOAD_W-1:0];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[LOAD_W-2:0], 1'b0};
			rem_q <= alu_rsp.neg ? trial[LOAD_W-1:0] : alu_rsp.sum[LOAD_W-1:0];
		end
		if (state_q == ST_MAG)
			mag_q <= alu_rsp.sum[COUNT_WIDTH-1:0];
		if (state_q == ST_MUL)
			prod_q <= PROD_W'(mag_q) * PROD_W'(scale_q);
		// Clamp magnitude; negative side may reach one more than positive
		if (state_q == ST_SAT) begin
			if (cnt_neg)
				sat_q <= (prod_q > NEG_MAX) ? NEG_MAX[ANGLE_W-1:0] : prod_q[ANGLE_W-1:0];
			else
				sat_q <= (prod_q > POS_MAX) ? POS_MAX[ANGLE_W-1:0] : prod_q[ANGLE_W-1:0];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q   <= POS_W'(count_q);
			out_dir_q   <= dir_q;
			out_angle_q <= alu_rsp.sum[ANGLE_W-1:0];
			out_miss_q  <= miss_q;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.position_count    = out_pos_q;
	assign res.turning_clockwise = out_dir_q;
	assign res.angle             = out_angle_q;
	assign res.missed_edge       = out_miss_q;

	// APB register writes
	assign cfg_wr = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= DEFAULT_LIMIT;
			scale_q  <= DEFAULT_SCALE;
			enable_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
				REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
				REG_ENABLE: enable_q <= pwdata[0];
				default:    enable_q <= enable_q;
			endcase
		end
	end

	// APB register reads
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_LIMIT:  prdata = APB_DATA_W'(limit_q);
			REG_SCALE:  prdata = APB_DATA_W'(scale_q);
			REG_ENABLE: prdata = APB_DATA_W'(enable_q);
			default:    prdata = '0;
		endcase
	end

	// The division step counter only runs inside the division loop
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (div_cnt_q == '0))
		else $error("division counter active outside division");

	// A counted step never carries a missed-edge flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> !miss_q)
		else $error("count step with missed edge");

	// Saturated angle magnitude never exceeds the negative limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ANG) |-> (PROD_W'(sat_q) <= NEG_MAX))
		else $error("angle magnitude out of range");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the quadrature decoder with wrapping position counter.
`timescale 1ns / 100ps

module testbench;
	import qdwc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int IDLE_SETTLE = 30;
	localparam longint unsigned ANG_POS_MAX = (64'd1 << (ANGLE_W - 1)) - 64'd1;
	localparam longint unsigned ANG_NEG_MAX = 64'd1 << (ANGLE_W - 1);

	typedef struct {
		logic                      opcode;
		logic                      pin_a;
		logic                      pin_b;
		logic signed [LOAD_W-1:0]  load_value;
	} decoder_req_t;

	typedef struct {
		logic signed [POS_W-1:0]   position_count;
		logic                      turning_clockwise;
		logic signed [ANGLE_W-1:0] angle;
		logic                      missed_edge;
	} decoder_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	qdwc_in_if  req_ch ();
	qdwc_out_if res_ch ();

	quadrature_decoder_wrap_counter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Requests waiting to be sent, and decoder outputs still owed by the block
	decoder_req_t    req_fifo[$];
	decoder_result_t due_results[$];

	// Shadow registers and decoder state
	logic [LIMIT_W-1:0]      lim_shadow;
	logic [SCALE_W-1:0]      scale_shadow;
	logic                    en_shadow;
	logic signed [POS_W-1:0] cnt_shadow;
	logic                    dir_shadow;
	logic                    prev_a;
	logic                    prev_b;

	// Stimulus shaping: position on the Gray cycle and walking direction
	logic [1:0] gray_pos;
	logic       walk_fwd;

	int error_count = 0;
	int cycle_count = 0;
	int sent_count  = 0;
	int src_wait    = 0;
	int result_count = 0;
	int rcv_stall   = 0;

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Saturated angle for a count
	function automatic logic signed [ANGLE_W-1:0] angle_of(input int c);
		longint unsigned mag;
		longint unsigned prod;
		mag = (c < 0) ? longint'(-c) : longint'(c);
		prod = mag * longint'(scale_shadow);
		if (c < 0) begin
			if (prod > ANG_NEG_MAX)
				prod = ANG_NEG_MAX;
			prod = -prod;
		end else if (prod > ANG_POS_MAX) begin
			prod = ANG_POS_MAX;
		end
		return ANGLE_W'(prod);
	endfunction

	// Advance the shadow decoder by one request and return its output
	function automatic decoder_result_t decode_request(input decoder_req_t r);
		int              eff;
		int              nxt;
		logic            ea;
		logic            eb;
		logic            cw;
		decoder_result_t out;
		eff = (lim_shadow == '0) ? 1 : int'(lim_shadow);
		out.missed_edge = 1'b0;
		if (r.opcode == OP_LOAD) begin
			// truncating remainder keeps the sign of the load value
			nxt = int'(r.load_value) % (2 * eff);
			cnt_shadow = POS_W'(nxt);
		end else begin
			ea = r.pin_a != prev_a;
			eb = r.pin_b != prev_b;
			prev_a = r.pin_a;
			prev_b = r.pin_b;
			if (en_shadow) begin
				if (ea && eb) begin
					out.missed_edge = 1'b1;
				end else if (ea || eb) begin
					cw = ea ? (r.pin_a == r.pin_b) : (r.pin_a != r.pin_b);
					dir_shadow = cw;
					nxt = int'(cnt_shadow) + (cw ? 1 : -1);
					if (nxt >= eff)
						nxt -= 2 * eff;
					else if (nxt <= -eff)
						nxt += 2 * eff;
					cnt_shadow = POS_W'(nxt);
				end
			end
		end
		out.position_count = cnt_shadow;
		out.turning_clockwise = dir_shadow;
		out.angle = angle_of(int'(cnt_shadow));
		return out;
	endfunction

	task automatic queue_req(input logic op, input logic a, input logic b,
		input logic [LOAD_W-1:0] lv);
		decoder_req_t r;
		r.opcode = op;
		r.pin_a = a;
		r.pin_b = b;
		r.load_value = lv;
		req_fifo.push_back(r);
	endtask

	// Mostly clean Gray-code walks, with holds, double steps and rare loads
	task automatic queue_random(input int n);
		int              r;
		int              eff;
		logic [LOAD_W-1:0] lv;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			lv = LOAD_W'($urandom);
			if (r < 5) begin
				eff = (lim_shadow == '0) ? 1 : int'(lim_shadow);
				if (r < 2)
					lv = LOAD_W'(($urandom_range(0, 1) ? eff : -eff) +
						int'($urandom_range(0, 4)) - 2);
				queue_req(OP_LOAD, 1'($urandom), 1'($urandom), lv);
			end else begin
				if (r < 9) begin
					gray_pos = gray_pos + 2'd2;
				end else if (r >= 15) begin
					if ($urandom_range(0, 9) == 0)
						walk_fwd = !walk_fwd;
					gray_pos = gray_pos + (walk_fwd ? 2'd1 : 2'd3);
				end
				queue_req(OP_SAMPLE, gray_pos[1], gray_pos[1] ^ gray_pos[0], lv);
			end
		end
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_LIMIT:  lim_shadow = data[LIMIT_W-1:0];
			REG_SCALE:  scale_shadow = data[SCALE_W-1:0];
			REG_ENABLE: en_shadow = data[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int lim, input logic [SCALE_W-1:0] scale, input logic en);
		reg_write(REG_LIMIT, APB_DATA_W'(lim));
		reg_write(REG_SCALE, scale);
		reg_write(REG_ENABLE, APB_DATA_W'(en));
	endtask

	// Wait until every request is sent and every output has come back
	task automatic wait_idle();
		do @(posedge clk);
		while (req_fifo.size() != 0 || req_ch.valid || due_results.size() != 0);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// Request driver
	always @(posedge clk) begin
		decoder_req_t cur;
		decoder_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			src_wait <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				cur.opcode = req_ch.opcode;
				cur.pin_a = req_ch.pin_a;
				cur.pin_b = req_ch.pin_b;
				cur.load_value = req_ch.load_value;
				due_results.push_back(decode_request(cur));
				sent_count <= sent_count + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (src_wait > 0) begin
					src_wait <= src_wait - 1;
					req_ch.valid <= 1'b0;
				end else if (req_fifo.size() > 0) begin
					nxt = req_fifo.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.opcode <= nxt.opcode;
					req_ch.pin_a <= nxt.pin_a;
					req_ch.pin_b <= nxt.pin_b;
					req_ch.load_value <= nxt.load_value;
					// every third stretch of requests goes back to back
					src_wait <= ((sent_count / 150) % 3 == 1) ? 0 : $urandom_range(0, 18);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result ready: random stalls, idle-free stretches, and a long hold-off now and then
	always @(posedge clk) begin
		int d;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rcv_stall <= 0;
		end else if (res_ch.valid && res_ch.ready) begin
			if (result_count % 450 == 300)
				d = 250;
			else
				d = ((result_count / 120) % 3 == 2) ? 0 : $urandom_range(0, 18);
			result_count <= result_count + 1;
			rcv_stall <= d;
			res_ch.ready <= (d == 0);
		end else if (rcv_stall > 0) begin
			rcv_stall <= rcv_stall - 1;
			res_ch.ready <= (rcv_stall == 1);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		decoder_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: position_count %0d", res_ch.position_count);
				error_count++;
			end else begin
				want = due_results.pop_front();
				if (res_ch.position_count !== want.position_count) begin
					$error("position_count: expected %0d, got %0d",
						want.position_count, res_ch.position_count);
					error_count++;
				end
				if (res_ch.turning_clockwise !== want.turning_clockwise) begin
					$error("turning_clockwise: expected %0b, got %0b",
						want.turning_clockwise, res_ch.turning_clockwise);
					error_count++;
				end
				if (res_ch.angle !== want.angle) begin
					$error("angle: expected %0d, got %0d", want.angle, res_ch.angle);
					error_count++;
				end
				if (res_ch.missed_edge !== want.missed_edge) begin
					$error("missed_edge: expected %0b, got %0b",
						want.missed_edge, res_ch.missed_edge);
					error_count++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_SAMPLE;
		req_ch.pin_a = 1'b1;
		req_ch.pin_b = 1'b1;
		req_ch.load_value = '0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lim_shadow = DEFAULT_LIMIT;
		scale_shadow = DEFAULT_SCALE;
		en_shadow = 1'b0;
		cnt_shadow = '0;
		dir_shadow = 1'b1;
		prev_a = 1'b1;
		prev_b = 1'b1;
		gray_pos = 2'd2;
		walk_fwd = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Decoder disabled after reset: pins tracked, count held; loads still work
		queue_req(OP_SAMPLE, 1'b0, 1'b0, 16'h7fff);
		queue_req(OP_SAMPLE, 1'b1, 1'b1, 16'h8000);
		queue_req(OP_LOAD, 1'b1, 1'b0, 16'd100);
		queue_req(OP_LOAD, 1'b0, 1'b1, 16'h8000);
		queue_req(OP_LOAD, 1'b0, 1'b0, 16'h7fff);
		wait_idle();

		// Small limit: clockwise walk across the top wrap, hold, missed edge, reverse walk
		set_config(4, DEFAULT_SCALE, 1'b1);
		queue_req(OP_LOAD, 1'b1, 1'b1, 16'd0);
		queue_req(OP_SAMPLE, 1'b1, 1'b0, 16'hffff);
		queue_req(OP_SAMPLE, 1'b0, 1'b0, 16'h0000);
		queue_req(OP_SAMPLE, 1'b0, 1'b1, 16'h1234);
		queue_req(OP_SAMPLE, 1'b1, 1'b1, 16'hedcb);
		queue_req(OP_SAMPLE, 1'b1, 1'b0, 16'h5555);
		queue_req(OP_SAMPLE, 1'b1, 1'b0, 16'haaaa);
		queue_req(OP_SAMPLE, 1'b0, 1'b1, 16'h0001);
		queue_req(OP_SAMPLE, 1'b0, 1'b0, 16'h8001);
		queue_req(OP_SAMPLE, 1'b1, 1'b0, 16'h7ffe);
		queue_req(OP_SAMPLE, 1'b1, 1'b1, 16'h0f0f);
		queue_req(OP_SAMPLE, 1'b0, 1'b1, 16'hf0f0);
		queue_req(OP_LOAD, 1'b0, 1'b0, 16'hfff9);
		queue_req(OP_LOAD, 1'b1, 1'b1, 16'h7fff);
		wait_idle();

		// Zero limit acts as one; full-scale angle
		set_config(0, 32'hffff_ffff, 1'b1);
		queue_req(OP_LOAD, 1'b0, 1'b0, 16'd5);
		queue_req(OP_SAMPLE, 1'b1, 1'b1, 16'h0000);
		queue_req(OP_SAMPLE, 1'b1, 1'b0, 16'h0000);
		wait_idle();

		// Largest limit: angle saturates both ways, most negative load
		set_config(16383, 32'hffff_ffff, 1'b1);
		queue_req(OP_LOAD, 1'b1, 1'b0, 16'd16382);
		queue_req(OP_SAMPLE, 1'b0, 1'b0, 16'h0000);
		queue_req(OP_LOAD, 1'b0, 1'b1, 16'h8000);
		wait_idle();

		// Zero scale
		set_config(16383, 32'd0, 1'b1);
		queue_req(OP_SAMPLE, 1'b0, 1'b1, 16'h0000);
		wait_idle();

		// Random phases over several settings
		set_config($urandom_range(1, 8), $urandom, 1'b1);
		queue_random(250);
		wait_idle();

		set_config(16383, 32'hffff_ffff, 1'b1);
		queue_random(200);
		wait_idle();

		set_config(0, $urandom, 1'b1);
		queue_random(150);
		wait_idle();

		set_config($urandom_range(1, 16383), $urandom, 1'b0);
		queue_random(100);
		wait_idle();

		set_config(2048, DEFAULT_SCALE, 1'b1);
		queue_random(200);
		wait_idle();

		set_config($urandom_range(1, 40), $urandom_range(0, 32'h0400_0000), 1'b1);
		queue_random(250);
		wait_idle();

		set_config(1, 32'hffff_ffff, 1'b1);
		queue_random(200);
		wait_idle();

		if (error_count == 0 && due_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/qdwc_pkg.sv
hdl/qdwc_if.sv
hdl/qdwc_alu.sv
hdl/quadrature_decoder_wrap_counter.sv
tb/testbench.sv
